// ===== rtl/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants for the cuboid reflection point block
// Word layouts, fixed-point widths, register indexes and wall codes.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int COORD_BITS = 32;
  localparam int LEN_BITS   = COORD_BITS - 1;
  localparam int SH_BITS    = COORD_BITS + 1;   // coordinate relative to room corner
  localparam int NUM_BITS   = COORD_BITS + 2;   // plane - mic
  localparam int DIF_BITS   = COORD_BITS + 3;   // image - mic
  localparam int MAG_A      = NUM_BITS - 1;
  localparam int MAG_B      = DIF_BITS - 1;
  localparam int QBITS      = COORD_BITS + 2;   // quotient bits kept, larger saturates
  localparam int SPLIT      = (MAG_B + 1) / 2;
  localparam int PP_BITS    = MAG_A + SPLIT;
  localparam int DVD_BITS   = MAG_A + MAG_B + 1;
  localparam int STEP_BITS  = 2;
  localparam int DIV_STAGES = QBITS / STEP_BITS;
  localparam int LANE_LAT   = 4 + DIV_STAGES;
  localparam int SUM_BITS   = COORD_BITS + 4;
  localparam int N_LANES    = 4;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX =
    {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COORD_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORG_X  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORG_Y  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORG_Z  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 3'd6;

  localparam logic [LEN_BITS-1:0] LEN_X_RST = 31'd327680;
  localparam logic [LEN_BITS-1:0] LEN_Y_RST = 31'd262144;
  localparam logic [LEN_BITS-1:0] LEN_Z_RST = 31'd196608;

  localparam int POINT_BITS = 4;
  localparam int WALL_BITS  = 3;
  localparam logic [POINT_BITS-1:0] FIRST_PTS   = 4'd6;
  localparam logic [POINT_BITS-1:0] LAST_FIRST  = 4'd5;
  localparam logic [POINT_BITS-1:0] LAST_SECOND = 4'd9;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [WALL_BITS-1:0] WALL_X_LO = 3'd0;
  localparam logic [WALL_BITS-1:0] WALL_Y_LO = 3'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] source_x;
    logic signed [COORD_BITS-1:0] source_y;
    logic signed [COORD_BITS-1:0] source_z;
    logic signed [COORD_BITS-1:0] mic_x;
    logic signed [COORD_BITS-1:0] mic_y;
    logic signed [COORD_BITS-1:0] mic_z;
  } crp_in_t;

  typedef struct packed {
    logic [POINT_BITS-1:0]        point_index;
    logic [WALL_BITS-1:0]         wall_code;
    logic signed [COORD_BITS-1:0] hit_x;
    logic signed [COORD_BITS-1:0] hit_y;
    logic signed [COORD_BITS-1:0] hit_z;
    logic                         degenerate;
    logic                         last_point;
  } crp_out_t;

endpackage

// ===== rtl/crp_in_if.sv =====
// ----------------------------------------------------------------------------
// crp_in_if: input channel
// Valid/ready channel carrying one source and microphone position per word.
// ----------------------------------------------------------------------------
interface crp_in_if;
  logic             valid;
  logic             ready;
  crp_pkg::crp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/crp_out_if.sv =====
// ----------------------------------------------------------------------------
// crp_out_if: output channel
// Valid/ready channel carrying one reflection point per word.
// ----------------------------------------------------------------------------
interface crp_out_if;
  logic              valid;
  logic              ready;
  crp_pkg::crp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/crp_lane.sv =====
// ----------------------------------------------------------------------------
// crp_lane: pipelined round(num * dt / den)
// Magnitudes, split multiply, rounding bias, then a restoring divider with
// two quotient bits per stage. Quotients of 2^QBITS or more flag ovf_o.
// ----------------------------------------------------------------------------
module crp_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [crp_pkg::NUM_BITS-1:0] num_i,
  input  logic signed [crp_pkg::DIF_BITS-1:0] dt_i,
  input  logic signed [crp_pkg::DIF_BITS-1:0] den_i,
  output logic        [crp_pkg::QBITS-1:0]    q_o,
  output logic                                ovf_o,
  output logic                                neg_o
);
  import crp_pkg::*;

  logic [NUM_BITS-1:0] na;
  logic [DIF_BITS-1:0] ta, da;

  logic [MAG_A-1:0]    ua_q;
  logic [MAG_B-1:0]    ub_q, uc1_q, uc2_q, uc3_q;
  logic                neg1_q, neg2_q, neg3_q;
  logic [PP_BITS-1:0]  plo_q, phi_q;
  logic [DVD_BITS-1:0] u_q;

  logic [MAG_B-1:0] rem_q [0:DIV_STAGES];
  logic [QBITS-1:0] sh_q  [0:DIV_STAGES];
  logic [MAG_B-1:0] uc_q  [0:DIV_STAGES];
  logic             neg_q [0:DIV_STAGES];
  logic             ovf_q [0:DIV_STAGES];
  logic [MAG_B-1:0] rem_d [1:DIV_STAGES];
  logic [QBITS-1:0] sh_d  [1:DIV_STAGES];

  assign na = num_i[NUM_BITS-1] ? NUM_BITS'(-num_i) : NUM_BITS'(num_i);
  assign ta = dt_i[DIF_BITS-1]  ? DIF_BITS'(-dt_i)  : DIF_BITS'(dt_i);
  assign da = den_i[DIF_BITS-1] ? DIF_BITS'(-den_i) : DIF_BITS'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q   <= na[MAG_A-1:0];
      ub_q   <= ta[MAG_B-1:0];
      uc1_q  <= da[MAG_B-1:0];
      neg1_q <= num_i[NUM_BITS-1] ^ dt_i[DIF_BITS-1] ^ den_i[DIF_BITS-1];

      plo_q  <= PP_BITS'(ua_q) * PP_BITS'(ub_q[SPLIT-1:0]);
      phi_q  <= PP_BITS'(ua_q) * PP_BITS'(ub_q[MAG_B-1:SPLIT]);
      uc2_q  <= uc1_q;
      neg2_q <= neg1_q;

      // product plus half the divisor gives round half away from zero
      u_q    <= DVD_BITS'(plo_q) + (DVD_BITS'(phi_q) << SPLIT) + DVD_BITS'(uc2_q >> 1);
      uc3_q  <= uc2_q;
      neg3_q <= neg2_q;

      rem_q[0] <= u_q[DVD_BITS-1:QBITS];
      sh_q[0]  <= u_q[QBITS-1:0];
      ovf_q[0] <= u_q[DVD_BITS-1:QBITS] >= uc3_q;
      uc_q[0]  <= uc3_q;
      neg_q[0] <= neg3_q;
    end
  end

  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_div
    always_comb begin : step
      logic [MAG_B:0]   t;
      logic [MAG_B-1:0] r;
      logic [QBITS-1:0] s;
      r = rem_q[i-1];
      s = sh_q[i-1];
      t = '0;
      for (int j = 0; j < STEP_BITS; j++) begin
        t = {r, s[QBITS-1]};
        s = {s[QBITS-2:0], 1'b0};
        if (t >= {1'b0, uc_q[i-1]}) begin
          t    = t - {1'b0, uc_q[i-1]};
          s[0] = 1'b1;
        end
        r = t[MAG_B-1:0];
      end
      rem_d[i] = r;
      sh_d[i]  = s;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d[i];
        sh_q[i]  <= sh_d[i];
        uc_q[i]  <= uc_q[i-1];
        neg_q[i] <= neg_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  assign q_o   = sh_q[DIV_STAGES];
  assign ovf_o = ovf_q[DIV_STAGES];
  assign neg_o = neg_q[DIV_STAGES];

endmodule

// ===== rtl/cuboid_reflection_points_top.sv =====
// ----------------------------------------------------------------------------
// cuboid_reflection_points_top: wall reflection points of a box room
// Mirror-image cuts of the mic-to-image line with each wall plane.
// ----------------------------------------------------------------------------
// Each input word (source and mic position) expands into six points, or ten
// in second-order mode, issued one per cycle into a stalling pipeline; the
// output port moves one point word per cycle, so while the output is ready
// a new input is taken as the last point of the previous one issues. Each
// point needs up to four rounded multiply-divides, done by four pipelined
// lanes of a 33x34 split multiply and a 2-bit-per-stage restoring divider.
// The whole pipe holds while a finished word waits at the output.
module cuboid_reflection_points_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  crp_in_if.sink                                 in_i,
  crp_out_if.source                              out_o,
  input  logic                                   cfg_we_i,
  input  logic [crp_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [crp_pkg::CFG_DATA_BITS-1:0]      cfg_data_i
);
  import crp_pkg::*;

  typedef struct packed {
    logic                             last;
    logic [POINT_BITS-1:0]            pidx;
    logic                             corner;
    logic [1:0]                       ax0;
    logic [WALL_BITS-1:0]             wall0;
    logic                             yh;
    logic                             dg0;
    logic                             dg1;
    logic [LEN_BITS-1:0]              pl0;
    logic [LEN_BITS-1:0]              pl1;
    logic [2:0][COORD_BITS-1:0]       mic;
    logic [2:0][SH_BITS-1:0]          msh;
  } meta_t;

  // ---------------- helpers
  function automatic logic [SUM_BITS-1:0] qext(logic [QBITS-1:0] q, logic neg);
    logic [SUM_BITS-1:0] e;
    e = SUM_BITS'(q);
    return neg ? -e : e;
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_c(logic signed [SUM_BITS-1:0] v);
    if (v > SUM_MAX) return COORD_MAX;
    else if (v < SUM_MIN) return COORD_MIN;
    else return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] coord_out(logic signed [COORD_BITS-1:0] mic,
                                                      logic [QBITS-1:0] q,
                                                      logic ovf, logic neg);
    logic signed [SUM_BITS-1:0] v;
    v = SUM_BITS'(mic) + $signed(qext(q, neg));
    if (ovf) return neg ? COORD_MIN : COORD_MAX;
    else return sat_c(v);
  endfunction

  function automatic logic in_room(logic signed [SH_BITS-1:0] msh, logic [QBITS-1:0] q,
                                   logic ovf, logic neg, logic [LEN_BITS-1:0] len);
    logic signed [SUM_BITS-1:0] h;
    logic signed [SUM_BITS-1:0] l;
    h = SUM_BITS'(msh) + $signed(qext(q, neg));
    l = $signed(SUM_BITS'(len));
    return !ovf && !h[SUM_BITS-1] && (h <= l);
  endfunction

  function automatic logic [COORD_BITS-1:0] plane_out(logic [LEN_BITS-1:0] pl,
                                                      logic signed [COORD_BITS-1:0] org);
    logic signed [SUM_BITS-1:0] v;
    v = $signed(SUM_BITS'(pl)) + SUM_BITS'(org);
    return sat_c(v);
  endfunction

  // ---------------- configuration
  logic [LEN_BITS-1:0]          len_x_q, len_y_q, len_z_q;
  logic signed [COORD_BITS-1:0] org_x_q, org_y_q, org_z_q;
  logic                         mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_x_q <= LEN_X_RST;
      len_y_q <= LEN_Y_RST;
      len_z_q <= LEN_Z_RST;
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEN_X: len_x_q <= cfg_data_i[LEN_BITS-1:0];
        REG_LEN_Y: len_y_q <= cfg_data_i[LEN_BITS-1:0];
        REG_LEN_Z: len_z_q <= cfg_data_i[LEN_BITS-1:0];
        REG_ORG_X: org_x_q <= $signed(cfg_data_i);
        REG_ORG_Y: org_y_q <= $signed(cfg_data_i);
        REG_ORG_Z: org_z_q <= $signed(cfg_data_i);
        REG_MODE:  mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- input word and point sequencer
  logic                         adv, accept, job_last;
  logic                         busy_q, out_valid_q;
  logic [POINT_BITS-1:0]        pidx_q;
  logic signed [SH_BITS-1:0]    sx_q, sy_q, sz_q, mx_q, my_q, mz_q;
  logic [2:0][COORD_BITS-1:0]   mic_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign job_last   = pidx_q == (mode_q ? LAST_SECOND : LAST_FIRST);
  assign in_i.ready = adv && (!busy_q || job_last);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pidx_q <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      pidx_q <= '0;
    end else if (adv && busy_q) begin
      if (job_last) busy_q <= 1'b0;
      else pidx_q <= pidx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q  <= SH_BITS'(in_i.data.source_x) - SH_BITS'(org_x_q);
      sy_q  <= SH_BITS'(in_i.data.source_y) - SH_BITS'(org_y_q);
      sz_q  <= SH_BITS'(in_i.data.source_z) - SH_BITS'(org_z_q);
      mx_q  <= SH_BITS'(in_i.data.mic_x) - SH_BITS'(org_x_q);
      my_q  <= SH_BITS'(in_i.data.mic_y) - SH_BITS'(org_y_q);
      mz_q  <= SH_BITS'(in_i.data.mic_z) - SH_BITS'(org_z_q);
      mic_q <= {in_i.data.mic_z, in_i.data.mic_y, in_i.data.mic_x};
    end
  end

  // ---------------- stage A: image, differences, lane operands
  logic                         first, hi, xh, yh, fx, fy, fz;
  logic [1:0]                   ax, ax0, cc;
  logic [LEN_BITS-1:0]          plx, ply, plz, pl0;
  logic signed [DIF_BITS-1:0]   ix, iy, iz, dx, dy, dz, den0, dt0a, dt0b;
  logic signed [NUM_BITS-1:0]   nx, ny, nz, num0;
  meta_t                        meta_a;

  always_comb begin
    first = pidx_q < FIRST_PTS;
    ax    = pidx_q[2:1];
    hi    = pidx_q[0];
    cc    = 2'(pidx_q - FIRST_PTS);
    // corner order: xh/yl, xh/yh, xl/yh, xl/yl
    xh    = (cc == 2'd0) || (cc == 2'd1);
    yh    = (cc == 2'd1) || (cc == 2'd2);
    fx    = first ? (ax == AXIS_X) : 1'b1;
    fy    = first ? (ax == AXIS_Y) : 1'b1;
    fz    = first && (ax == AXIS_Z);
    plx   = (first ? (fx && hi) : xh) ? len_x_q : '0;
    ply   = (first ? (fy && hi) : yh) ? len_y_q : '0;
    plz   = (fz && hi) ? len_z_q : '0;
    ax0   = first ? ax : AXIS_X;

    ix = fx ? $signed(DIF_BITS'({plx, 1'b0})) - DIF_BITS'(sx_q) : DIF_BITS'(sx_q);
    iy = fy ? $signed(DIF_BITS'({ply, 1'b0})) - DIF_BITS'(sy_q) : DIF_BITS'(sy_q);
    iz = fz ? $signed(DIF_BITS'({plz, 1'b0})) - DIF_BITS'(sz_q) : DIF_BITS'(sz_q);
    dx = ix - DIF_BITS'(mx_q);
    dy = iy - DIF_BITS'(my_q);
    dz = iz - DIF_BITS'(mz_q);
    nx = $signed(NUM_BITS'(plx)) - NUM_BITS'(mx_q);
    ny = $signed(NUM_BITS'(ply)) - NUM_BITS'(my_q);
    nz = $signed(NUM_BITS'(plz)) - NUM_BITS'(mz_q);

    unique case (ax0)
      AXIS_X: begin
        den0 = dx; num0 = nx; dt0a = dy; dt0b = dz; pl0 = plx;
      end
      AXIS_Y: begin
        den0 = dy; num0 = ny; dt0a = dx; dt0b = dz; pl0 = ply;
      end
      default: begin
        den0 = dz; num0 = nz; dt0a = dx; dt0b = dy; pl0 = plz;
      end
    endcase

    meta_a.last   = job_last;
    meta_a.pidx   = pidx_q;
    meta_a.corner = !first;
    meta_a.ax0    = ax0;
    meta_a.wall0  = first ? {ax, hi} : (WALL_X_LO | WALL_BITS'(xh));
    meta_a.yh     = yh;
    meta_a.dg0    = den0 == '0;
    meta_a.dg1    = dy == '0;
    meta_a.pl0    = pl0;
    meta_a.pl1    = ply;
    meta_a.mic    = mic_q;
    meta_a.msh    = {mz_q, my_q, mx_q};
  end

  logic signed [NUM_BITS-1:0] lane_num [N_LANES];
  logic signed [DIF_BITS-1:0] lane_dt  [N_LANES];
  logic signed [DIF_BITS-1:0] lane_den [N_LANES];
  logic [QBITS-1:0]           lane_q   [N_LANES];
  logic                       lane_ovf [N_LANES];
  logic                       lane_neg [N_LANES];

  meta_t meta_q [0:LANE_LAT];
  logic  vld_q  [0:LANE_LAT];

  // lanes 0/1: tangentials of the first cut; lanes 2/3: x and z of the y cut
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lane_num[0] <= num0; lane_dt[0] <= dt0a; lane_den[0] <= den0;
      lane_num[1] <= num0; lane_dt[1] <= dt0b; lane_den[1] <= den0;
      lane_num[2] <= ny;   lane_dt[2] <= dx;   lane_den[2] <= dy;
      lane_num[3] <= ny;   lane_dt[3] <= dz;   lane_den[3] <= dy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LANE_LAT; i++) begin
        meta_q[i] <= '0;
        vld_q[i]  <= 1'b0;
      end
    end else if (adv) begin
      meta_q[0] <= meta_a;
      vld_q[0]  <= busy_q;
      for (int i = 1; i <= LANE_LAT; i++) begin
        meta_q[i] <= meta_q[i-1];
        vld_q[i]  <= vld_q[i-1];
      end
    end
  end

  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    crp_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (lane_num[l]),
      .dt_i  (lane_dt[l]),
      .den_i (lane_den[l]),
      .q_o   (lane_q[l]),
      .ovf_o (lane_ovf[l]),
      .neg_o (lane_neg[l])
    );
  end

  // ---------------- stage F: add mic, saturate, on-face test
  meta_t                    mt, f_meta_q;
  logic                     f_vld_q;
  logic [COORD_BITS-1:0]    mic_a, mic_b;
  logic [SH_BITS-1:0]       msh_a, msh_b;
  logic [LEN_BITS-1:0]      len_a, len_b;
  logic signed [COORD_BITS-1:0] org0;
  logic [COORD_BITS-1:0]    c_q [N_LANES];
  logic [COORD_BITS-1:0]    norm0_q, norm1_q;
  logic [1:0]               inr_q;

  assign mt = meta_q[LANE_LAT];

  always_comb begin
    unique case (mt.ax0)
      AXIS_X: begin
        mic_a = mt.mic[1]; msh_a = mt.msh[1]; len_a = len_y_q;
        mic_b = mt.mic[2]; msh_b = mt.msh[2]; len_b = len_z_q;
        org0  = org_x_q;
      end
      AXIS_Y: begin
        mic_a = mt.mic[0]; msh_a = mt.msh[0]; len_a = len_x_q;
        mic_b = mt.mic[2]; msh_b = mt.msh[2]; len_b = len_z_q;
        org0  = org_y_q;
      end
      default: begin
        mic_a = mt.mic[0]; msh_a = mt.msh[0]; len_a = len_x_q;
        mic_b = mt.mic[1]; msh_b = mt.msh[1]; len_b = len_y_q;
        org0  = org_z_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (adv) begin
      f_vld_q <= vld_q[LANE_LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_meta_q <= mt;
      c_q[0]   <= coord_out($signed(mic_a), lane_q[0], lane_ovf[0], lane_neg[0]);
      c_q[1]   <= coord_out($signed(mic_b), lane_q[1], lane_ovf[1], lane_neg[1]);
      c_q[2]   <= coord_out($signed(mt.mic[0]), lane_q[2], lane_ovf[2], lane_neg[2]);
      c_q[3]   <= coord_out($signed(mt.mic[2]), lane_q[3], lane_ovf[3], lane_neg[3]);
      inr_q[0] <= in_room($signed(msh_a), lane_q[0], lane_ovf[0], lane_neg[0], len_a);
      inr_q[1] <= in_room($signed(msh_b), lane_q[1], lane_ovf[1], lane_neg[1], len_b);
      norm0_q  <= plane_out(mt.pl0, org0);
      norm1_q  <= plane_out(mt.pl1, org_y_q);
    end
  end

  // ---------------- output register: pick cut, assemble word
  logic     use_x;
  crp_out_t out_d, out_q;

  always_comb begin
    use_x = !f_meta_q.corner || (!f_meta_q.dg0 && inr_q[0] && inr_q[1]);
    out_d.point_index = f_meta_q.pidx;
    out_d.last_point  = f_meta_q.last;
    if (use_x) begin
      out_d.wall_code  = f_meta_q.wall0;
      out_d.degenerate = f_meta_q.dg0;
      unique case (f_meta_q.ax0)
        AXIS_X: begin
          out_d.hit_x = norm0_q; out_d.hit_y = c_q[0]; out_d.hit_z = c_q[1];
        end
        AXIS_Y: begin
          out_d.hit_x = c_q[0]; out_d.hit_y = norm0_q; out_d.hit_z = c_q[1];
        end
        default: begin
          out_d.hit_x = c_q[0]; out_d.hit_y = c_q[1]; out_d.hit_z = norm0_q;
        end
      endcase
    end else begin
      out_d.wall_code  = WALL_Y_LO | WALL_BITS'(f_meta_q.yh);
      out_d.degenerate = f_meta_q.dg1;
      out_d.hit_x      = c_q[2];
      out_d.hit_y      = norm1_q;
      out_d.hit_z      = c_q[3];
    end
    if (out_d.degenerate) begin
      out_d.hit_x = '0;
      out_d.hit_y = '0;
      out_d.hit_z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
